// File: src/ssd_pkg.sv
// Shared types, constants and helper functions for the speech segment detector.
// No dependencies; every other file in src uses this package.
package ssd_pkg;

    localparam int IDX_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int PROB_W     = 17;
    localparam int MINC_W     = 12;
    localparam int PAD_IN_W   = 16;
    localparam int OUT_IDX_W  = 24;
    localparam int OUT_PAD_W  = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;
    localparam int PADV_W     = ((IDX_W + FRAC_W) > OUT_PAD_W ? IDX_W + FRAC_W : OUT_PAD_W) + 1;
    localparam int CMP_W      = (IDX_W > MINC_W ? IDX_W : MINC_W) + 2;
    localparam int EXT_W      = IDX_W + OUT_IDX_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [IDX_W-1:0]    IDX_MAX          = '1;
    localparam logic [PROB_W-1:0]   START_TH_RST     = 17'd32768;
    localparam logic [PROB_W-1:0]   STOP_TH_RST      = 17'd22938;
    localparam logic [MINC_W-1:0]   MIN_SIL_RST      = 12'd2;
    localparam logic [MINC_W-1:0]   MIN_SEG_RST      = 12'd3;
    localparam logic [PAD_IN_W-1:0] PAD_RST          = 16'd80;

    typedef enum logic [2:0] {
        REG_START_TH   = 3'd0,
        REG_STOP_TH    = 3'd1,
        REG_MIN_SIL    = 3'd2,
        REG_MIN_SEG    = 3'd3,
        REG_PAD        = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PROB_W-1:0]   start_th;
        logic [PROB_W-1:0]   stop_th;
        logic [MINC_W-1:0]   min_sil;
        logic [MINC_W-1:0]   min_seg_len;
        logic [PAD_IN_W-1:0] pad;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] seg_start;
        logic [IDX_W-1:0] seg_end;
        logic             last;
    } seg_t;

    typedef struct packed {
        logic v0;
        logic v1;
        seg_t w0;
        seg_t w1;
    } push_t;

    typedef struct packed {
        logic in_speech;
        logic held_valid;
        logic count_zero;
    } fst_t;

    function automatic logic [PADV_W-1:0] pad_start(input logic [IDX_W-1:0] idx,
                                                    input logic [PAD_IN_W-1:0] pad);
        logic [PADV_W-1:0] v;
        logic [PADV_W-1:0] p;
        v = PADV_W'(idx) << FRAC_W;
        p = PADV_W'(pad);
        return (v < p) ? '0 : v - p;
    endfunction

    function automatic logic [PADV_W-1:0] pad_end(input logic [IDX_W-1:0] idx,
                                                  input logic [PAD_IN_W-1:0] pad);
        return (PADV_W'(idx) << FRAC_W) + PADV_W'(pad);
    endfunction

    function automatic logic [OUT_PAD_W-1:0] sat_out(input logic [PADV_W-1:0] v);
        return (|v[PADV_W-1:OUT_PAD_W]) ? '1 : v[OUT_PAD_W-1:0];
    endfunction

    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] t;
        t = EXT_W'(idx);
        return t[OUT_IDX_W-1:0];
    endfunction

endpackage

// File: src/ssd_front.sv
// Front end: accepts words, runs the hysteresis rule and the held-segment merge.
// Pushes up to two finished segments per word into the queue. Uses ssd_pkg.
module ssd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        action,
    input  logic [ssd_pkg::PROB_W-1:0]  probability,
    input  ssd_pkg::cfg_t               cfg,
    output ssd_pkg::push_t              push,
    output ssd_pkg::fst_t               status
);

    logic                       in_speech_reg,     in_speech_next;
    logic [ssd_pkg::IDX_W-1:0]  speech_begin_reg,  speech_begin_next;
    logic [ssd_pkg::IDX_W-1:0]  silence_begin_reg, silence_begin_next;
    logic [ssd_pkg::IDX_W-1:0]  chunk_count_reg,   chunk_count_next;
    logic                       held_valid_reg,    held_valid_next;
    logic [ssd_pkg::IDX_W-1:0]  held_start_reg,    held_start_next;
    logic [ssd_pkg::IDX_W-1:0]  held_end_reg,      held_end_next;

    logic                              above;
    logic                              below;
    logic [ssd_pkg::IDX_W-1:0]         sil;
    logic [ssd_pkg::IDX_W-1:0]         cs;
    logic [ssd_pkg::IDX_W-1:0]         ce;
    logic [ssd_pkg::IDX_W-1:0]         endc;
    logic                              do_comb;
    logic                              merge;
    logic                              has_a;
    logic                              flush;
    logic signed [ssd_pkg::CMP_W-1:0]  d_idle;
    logic signed [ssd_pkg::CMP_W-1:0]  d_seg;
    logic signed [ssd_pkg::CMP_W-1:0]  d_len;
    ssd_pkg::seg_t                     emit_a;
    ssd_pkg::seg_t                     emit_b;
    ssd_pkg::push_t                    push_c;

    always_comb
    begin
        in_speech_next     = in_speech_reg;
        speech_begin_next  = speech_begin_reg;
        silence_begin_next = silence_begin_reg;
        chunk_count_next   = chunk_count_reg;
        held_valid_next    = held_valid_reg;
        held_start_next    = held_start_reg;
        held_end_next      = held_end_reg;

        above   = probability >= cfg.start_th;
        below   = probability < cfg.stop_th;
        sil     = silence_begin_reg;
        endc    = chunk_count_reg - ssd_pkg::IDX_W'(1);
        d_len   = signed'(ssd_pkg::CMP_W'(endc) - ssd_pkg::CMP_W'(speech_begin_reg));
        d_idle  = '0;
        d_seg   = '0;
        do_comb = 1'b0;
        cs      = speech_begin_reg;
        ce      = endc;

        if (action)
        begin
            if (in_speech_reg && chunk_count_reg != '0 &&
                d_len > signed'(ssd_pkg::CMP_W'(cfg.min_seg_len)))
            begin
                do_comb = 1'b1;
            end
        end
        else
        begin
            if (above)
            begin
                sil = '0;
            end
            if (!in_speech_reg)
            begin
                if (above)
                begin
                    in_speech_next    = 1'b1;
                    speech_begin_next = chunk_count_reg;
                end
            end
            else if (below)
            begin
                if (sil == '0)
                begin
                    sil = chunk_count_reg;
                end
                d_idle = signed'(ssd_pkg::CMP_W'(chunk_count_reg) - ssd_pkg::CMP_W'(sil));
                if (d_idle >= signed'(ssd_pkg::CMP_W'(cfg.min_sil)))
                begin
                    d_seg = signed'(ssd_pkg::CMP_W'(sil) - ssd_pkg::CMP_W'(speech_begin_reg));
                    if (d_seg >= signed'(ssd_pkg::CMP_W'(cfg.min_seg_len)))
                    begin
                        do_comb = 1'b1;
                        ce      = sil;
                    end
                    speech_begin_next = '0;
                    sil               = '0;
                    in_speech_next    = 1'b0;
                end
            end
            silence_begin_next = sil;
            if (chunk_count_reg != ssd_pkg::IDX_MAX)
            begin
                chunk_count_next = chunk_count_reg + ssd_pkg::IDX_W'(1);
            end
        end

        // merge test on unsaturated padded values
        merge = held_valid_reg &&
                (ssd_pkg::pad_end(held_end_reg, cfg.pad) >= ssd_pkg::pad_start(cs, cfg.pad));
        has_a = do_comb && held_valid_reg && !merge;

        if (do_comb)
        begin
            held_valid_next = 1'b1;
            held_end_next   = ce;
            if (!merge)
            begin
                held_start_next = cs;
            end
        end

        flush            = action && held_valid_next;
        emit_a.seg_start = held_start_reg;
        emit_a.seg_end   = held_end_reg;
        emit_a.last      = !flush;
        emit_b.seg_start = held_start_next;
        emit_b.seg_end   = held_end_next;
        emit_b.last      = 1'b1;

        if (has_a)
        begin
            push_c.v0 = 1'b1;
            push_c.w0 = emit_a;
            push_c.v1 = flush;
            push_c.w1 = emit_b;
        end
        else
        begin
            push_c.v0 = flush;
            push_c.w0 = emit_b;
            push_c.v1 = 1'b0;
            push_c.w1 = emit_b;
        end

        if (action)
        begin
            in_speech_next     = 1'b0;
            speech_begin_next  = '0;
            silence_begin_next = '0;
            chunk_count_next   = '0;
            held_valid_next    = 1'b0;
            held_start_next    = '0;
            held_end_next      = '0;
        end
    end

    always_comb
    begin
        push    = push_c;
        push.v0 = push_c.v0 & accept;
        push.v1 = push_c.v1 & accept;
    end

    assign status.in_speech  = in_speech_reg;
    assign status.held_valid = held_valid_reg;
    assign status.count_zero = (chunk_count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_speech_reg     <= 1'b0;
            speech_begin_reg  <= '0;
            silence_begin_reg <= '0;
            chunk_count_reg   <= '0;
            held_valid_reg    <= 1'b0;
            held_start_reg    <= '0;
            held_end_reg      <= '0;
        end
        else if (accept)
        begin
            in_speech_reg     <= in_speech_next;
            speech_begin_reg  <= speech_begin_next;
            silence_begin_reg <= silence_begin_next;
            chunk_count_reg   <= chunk_count_next;
            held_valid_reg    <= held_valid_next;
            held_start_reg    <= held_start_next;
            held_end_reg      <= held_end_next;
        end
    end

endmodule

// File: src/ssd_queue.sv
// Short segment queue between front and back; takes up to two words per cycle.
// Uses ssd_pkg.
module ssd_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssd_pkg::push_t               push,
    input  logic                         pop,
    output ssd_pkg::seg_t                head,
    output logic [ssd_pkg::Q_CNT_W-1:0]  count
);

    ssd_pkg::seg_t                 mem_reg [ssd_pkg::Q_DEPTH];
    logic [ssd_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ssd_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ssd_pkg::Q_CNT_W-1:0]   count_reg,  count_next;
    logic [ssd_pkg::Q_PTR_W-1:0]   wr_ptr_1;

    assign wr_ptr_1 = wr_ptr_reg + ssd_pkg::Q_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ssd_pkg::Q_PTR_W'(push.v0) + ssd_pkg::Q_PTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + ssd_pkg::Q_PTR_W'(pop);
        count_next  = count_reg + ssd_pkg::Q_CNT_W'(push.v0) + ssd_pkg::Q_CNT_W'(push.v1)
                      - ssd_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.w0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_1] <= push.w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: src/ssd_back.sv
// Back end: pops segments, forms padded bounds and holds the output register.
// Uses ssd_pkg.
module ssd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ssd_pkg::cfg_t                   cfg,
    input  ssd_pkg::seg_t                   head,
    input  logic                            q_nonempty,
    input  logic                            out_stall,
    output logic                            pop,
    output logic                            out_valid,
    output logic [ssd_pkg::OUT_IDX_W-1:0]   start_chunk,
    output logic [ssd_pkg::OUT_IDX_W-1:0]   end_chunk,
    output logic [ssd_pkg::OUT_PAD_W-1:0]   start_padded,
    output logic [ssd_pkg::OUT_PAD_W-1:0]   end_padded,
    output logic                            last
);

    logic                            out_valid_reg,    out_valid_next;
    logic [ssd_pkg::OUT_IDX_W-1:0]   start_chunk_reg,  start_chunk_next;
    logic [ssd_pkg::OUT_IDX_W-1:0]   end_chunk_reg,    end_chunk_next;
    logic [ssd_pkg::OUT_PAD_W-1:0]   start_padded_reg, start_padded_next;
    logic [ssd_pkg::OUT_PAD_W-1:0]   end_padded_reg,   end_padded_next;
    logic                            last_reg,         last_next;

    assign pop = q_nonempty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next    = pop || (out_valid_reg && out_stall);
        start_chunk_next  = start_chunk_reg;
        end_chunk_next    = end_chunk_reg;
        start_padded_next = start_padded_reg;
        end_padded_next   = end_padded_reg;
        last_next         = last_reg;
        if (pop)
        begin
            start_chunk_next  = ssd_pkg::out_idx(head.seg_start);
            end_chunk_next    = ssd_pkg::out_idx(head.seg_end);
            start_padded_next = ssd_pkg::sat_out(ssd_pkg::pad_start(head.seg_start, cfg.pad));
            end_padded_next   = ssd_pkg::sat_out(ssd_pkg::pad_end(head.seg_end, cfg.pad));
            last_next         = head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_chunk_reg  <= start_chunk_next;
        end_chunk_reg    <= end_chunk_next;
        start_padded_reg <= start_padded_next;
        end_padded_reg   <= end_padded_next;
        last_reg         <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign start_chunk  = start_chunk_reg;
    assign end_chunk    = end_chunk_reg;
    assign start_padded = start_padded_reg;
    assign end_padded   = end_padded_reg;
    assign last         = last_reg;

endmodule

// File: src/speech_segment_detector.sv
// Top level of the speech segment detector: config registers, front, queue, back.
// Depends on ssd_pkg, ssd_front, ssd_queue and ssd_back.
//
//   channel   direction  handshake             word
//   in        input      in_valid / in_stall   action, probability
//   out       output     out_valid / out_stall start_chunk, end_chunk, start_padded,
//                                              end_padded, last
//   config    APB        psel/penable/pready   5 registers at 4*i
//
// One input word per cycle while in_stall is low; its results pass through the queue and the back-end output register.
// An end-of-stream word may give two results; the back end sends one per cycle while out_stall is low.
// in_stall rises when the 4-entry result queue has fewer than two free entries.
// Reset clears all segment state and loads default config; no clearing pass.
module speech_segment_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssd_pkg::ADDR_W-1:0]      paddr,
    input  logic [ssd_pkg::DATA_W-1:0]      pwdata,
    output logic [ssd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [ssd_pkg::PROB_W-1:0]      probability,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssd_pkg::OUT_IDX_W-1:0]   start_chunk,
    output logic [ssd_pkg::OUT_IDX_W-1:0]   end_chunk,
    output logic [ssd_pkg::OUT_PAD_W-1:0]   start_padded,
    output logic [ssd_pkg::OUT_PAD_W-1:0]   end_padded,
    output logic                            last
);

    ssd_pkg::cfg_t                  cfg_reg, cfg_next;
    ssd_pkg::reg_idx_t              reg_idx;
    logic                           cfg_we;
    logic                           in_acc;
    ssd_pkg::push_t                 push;
    ssd_pkg::fst_t                  fst;
    ssd_pkg::seg_t                  head;
    logic [ssd_pkg::Q_CNT_W-1:0]    q_count;
    logic                           q_pop;

    assign pready  = 1'b1;
    assign reg_idx = ssd_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx)
                ssd_pkg::REG_START_TH:   cfg_next.start_th    = pwdata[ssd_pkg::PROB_W-1:0];
                ssd_pkg::REG_STOP_TH:    cfg_next.stop_th     = pwdata[ssd_pkg::PROB_W-1:0];
                ssd_pkg::REG_MIN_SIL:    cfg_next.min_sil     = pwdata[ssd_pkg::MINC_W-1:0];
                ssd_pkg::REG_MIN_SEG:    cfg_next.min_seg_len = pwdata[ssd_pkg::MINC_W-1:0];
                ssd_pkg::REG_PAD:        cfg_next.pad         = pwdata[ssd_pkg::PAD_IN_W-1:0];
                default:                 cfg_next             = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ssd_pkg::REG_START_TH:   prdata = ssd_pkg::DATA_W'(cfg_reg.start_th);
            ssd_pkg::REG_STOP_TH:    prdata = ssd_pkg::DATA_W'(cfg_reg.stop_th);
            ssd_pkg::REG_MIN_SIL:    prdata = ssd_pkg::DATA_W'(cfg_reg.min_sil);
            ssd_pkg::REG_MIN_SEG:    prdata = ssd_pkg::DATA_W'(cfg_reg.min_seg_len);
            ssd_pkg::REG_PAD:        prdata = ssd_pkg::DATA_W'(cfg_reg.pad);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_th    <= ssd_pkg::START_TH_RST;
            cfg_reg.stop_th     <= ssd_pkg::STOP_TH_RST;
            cfg_reg.min_sil     <= ssd_pkg::MIN_SIL_RST;
            cfg_reg.min_seg_len <= ssd_pkg::MIN_SEG_RST;
            cfg_reg.pad         <= ssd_pkg::PAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // room for two results must be free before a word is taken
    assign in_stall = q_count > ssd_pkg::Q_CNT_W'(ssd_pkg::Q_DEPTH - 2);
    assign in_acc   = in_valid && !in_stall;

    ssd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_acc),
        .action      (action),
        .probability (probability),
        .cfg         (cfg_reg),
        .push        (push),
        .status      (fst)
    );

    ssd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (head),
        .count (q_count)
    );

    ssd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .q_nonempty   (q_count != '0),
        .out_stall    (out_stall),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .start_chunk  (start_chunk),
        .end_chunk    (end_chunk),
        .start_padded (start_padded),
        .end_padded   (end_padded),
        .last         (last)
    );

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action) |=> (!fst.in_speech && !fst.held_valid && fst.count_zero))
        else $error("end of stream did not clear segment state");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !action && !fst.in_speech && !fst.held_valid)
        |=> (q_count <= $past(q_count)))
        else $error("result queued with no open or held segment");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ssd_pkg::Q_CNT_W'(ssd_pkg::Q_DEPTH))
        else $error("result queue overflow");

endmodule

// File: bench/tb_speech_segment_detector.sv
`timescale 1ns / 1ps
// Testbench for speech_segment_detector: directed table, then random segment-shaped traffic.
// Expected segments come from an in-bench predictor; needs ssd_pkg and the RTL top level.
module tb_speech_segment_detector;

    localparam logic ACT_CHUNK = 1'b0;
    localparam logic ACT_END   = 1'b1;
    localparam int   FRAC      = 8;
    localparam longint COUNT_CAP = (64'd1 << 24) - 1;
    localparam longint SAT32     = 64'h0000_0000_FFFF_FFFF;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   LIMIT        = 200000;

    typedef struct packed {
        logic [23:0] start_chunk;
        logic [23:0] end_chunk;
        logic [31:0] start_padded;
        logic [31:0] end_padded;
        logic        last;
    } seg_word_t;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               act;
        logic [16:0]        prob;
        ssd_pkg::reg_idx_t  ri;
        logic [31:0]        val;
        bit                 typed;
        int                 n_typed;
        seg_word_t          res;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [ssd_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall, action;
    logic [16:0] probability;
    logic        out_valid, out_stall;
    logic [23:0] start_chunk, end_chunk;
    logic [31:0] start_padded, end_padded;
    logic        last;

    speech_segment_detector dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .probability(probability),
        .out_valid(out_valid), .out_stall(out_stall),
        .start_chunk(start_chunk), .end_chunk(end_chunk),
        .start_padded(start_padded), .end_padded(end_padded), .last(last)
    );

    // predictor copy of the registers
    logic [16:0] cfg_start, cfg_stop;
    logic [11:0] cfg_min_sil, cfg_min_sp;
    logic [15:0] cfg_pad;

    // predictor copy of the segment state
    bit     st_in_speech, st_held;
    longint st_sp_begin, st_sil_begin, st_count, st_held_s, st_held_e;

    seg_word_t seg_expect[$];
    seg_word_t step_out[$];
    plan_row_t plan[$];

    int fails, words_sent, ends_sent, segs_seen, cfg_writes, cycle_count;
    int send_idle_pct, recv_stall_pct, hold_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint lo_pad(input longint s);
        longint v;
        v = s << FRAC;
        return (v < longint'(cfg_pad)) ? 0 : v - longint'(cfg_pad);
    endfunction

    function automatic longint hi_pad(input longint e);
        return (e << FRAC) + longint'(cfg_pad);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        return (v > SAT32) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic emit_seg(input longint s, input longint e);
        seg_word_t r;
        r.start_chunk  = s[23:0];
        r.end_chunk    = e[23:0];
        r.start_padded = clip32(lo_pad(s));
        r.end_padded   = clip32(hi_pad(e));
        r.last         = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic merge_or_emit(input longint s, input longint e);
        if (st_held && hi_pad(st_held_e) >= lo_pad(s)) begin
            st_held_e = e;
        end else begin
            if (st_held)
                emit_seg(st_held_s, st_held_e);
            st_held   = 1'b1;
            st_held_s = s;
            st_held_e = e;
        end
    endtask

    task automatic clear_segments();
        st_in_speech = 1'b0;
        st_sp_begin  = 0;
        st_sil_begin = 0;
        st_count     = 0;
        st_held      = 1'b0;
        st_held_s    = 0;
        st_held_e    = 0;
    endtask

    task automatic segment_step(input logic act, input logic [16:0] p);
        longint idx, endc;
        bit above;
        step_out.delete();
        if (act == ACT_END) begin
            if (st_in_speech && st_count > 0) begin
                endc = st_count - 1;
                if (endc - st_sp_begin > longint'(cfg_min_sp))
                    merge_or_emit(st_sp_begin, endc);
            end
            if (st_held)
                emit_seg(st_held_s, st_held_e);
            clear_segments();
        end else begin
            idx   = st_count;
            above = (p >= cfg_start);
            if (above && st_sil_begin > 0)
                st_sil_begin = 0;
            if (!st_in_speech) begin
                if (above) begin
                    st_in_speech = 1'b1;
                    st_sp_begin  = idx;
                end
            end else if (p < cfg_stop) begin
                if (st_sil_begin == 0)
                    st_sil_begin = idx;
                if (idx - st_sil_begin >= longint'(cfg_min_sil)) begin
                    if (st_sil_begin - st_sp_begin >= longint'(cfg_min_sp))
                        merge_or_emit(st_sp_begin, st_sil_begin);
                    st_sp_begin  = 0;
                    st_sil_begin = 0;
                    st_in_speech = 1'b0;
                end
            end
            if (st_count < COUNT_CAP)
                st_count++;
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
    endtask

    // one word on the input channel; enters and leaves at a rising edge
    task automatic send_word(input logic act, input logic [16:0] p,
                             input bit typed, input int n_typed, input seg_word_t tres);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        probability <= p;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            if (!in_stall) begin
                taken = 1'b1;
                segment_step(act, p);
                if (typed) begin
                    if (n_typed > 0)
                        seg_expect.push_back(tres);
                end else begin
                    foreach (step_out[i])
                        seg_expect.push_back(step_out[i]);
                end
                words_sent++;
                if (act == ACT_END)
                    ends_sent++;
            end
            @(posedge clk);
        end
    endtask

    task automatic send_chunk(input logic act, input logic [16:0] p);
        send_word(act, p, 1'b0, 0, '0);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (seg_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input ssd_pkg::reg_idx_t ri,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ssd_pkg::ADDR_W'({ri, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input ssd_pkg::reg_idx_t ri, input logic [31:0] val);
        logic [31:0] rd, masked;
        case (ri)
            ssd_pkg::REG_START_TH: begin
                cfg_start = val[16:0];
                masked = 32'(val[16:0]);
            end
            ssd_pkg::REG_STOP_TH: begin
                cfg_stop = val[16:0];
                masked = 32'(val[16:0]);
            end
            ssd_pkg::REG_MIN_SIL: begin
                cfg_min_sil = val[11:0];
                masked = 32'(val[11:0]);
            end
            ssd_pkg::REG_MIN_SEG: begin
                cfg_min_sp = val[11:0];
                masked = 32'(val[11:0]);
            end
            default: begin
                cfg_pad = val[15:0];
                masked = 32'(val[15:0]);
            end
        endcase
        apb_xfer(1'b1, ri, val, rd);
        apb_xfer(1'b0, ri, 32'd0, rd);
        if (rd !== masked) begin
            $error("register %s readback: expected %0d, actual %0d", ri.name(), masked, rd);
            fails++;
        end
        cfg_writes++;
    endtask

    task automatic cfg_all(input logic [31:0] st, input logic [31:0] sp, input logic [31:0] msil,
                           input logic [31:0] mspeech, input logic [31:0] pad);
        cfg_write(ssd_pkg::REG_START_TH, st);
        cfg_write(ssd_pkg::REG_STOP_TH, sp);
        cfg_write(ssd_pkg::REG_MIN_SIL, msil);
        cfg_write(ssd_pkg::REG_MIN_SEG, mspeech);
        cfg_write(ssd_pkg::REG_PAD, pad);
    endtask

    task automatic cfg_random();
        logic [31:0] st, sp, pad;
        st = $urandom_range(16384, 60000);
        sp = ($urandom_range(3) == 0) ? $urandom_range(st, 65536) : $urandom_range(0, st);
        pad = ($urandom_range(5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1500);
        cfg_all(st, sp, $urandom_range(1, 5), $urandom_range(1, 5), pad);
    endtask

    function automatic logic [16:0] speech_p();
        return (cfg_start > 17'd65536) ? cfg_start : 17'($urandom_range(cfg_start, 65536));
    endfunction

    function automatic logic [16:0] quiet_p();
        return (cfg_stop == 0) ? 17'd0 : 17'($urandom_range(0, cfg_stop - 1));
    endfunction

    function automatic logic [16:0] between_p();
        if (cfg_start > cfg_stop)
            return 17'($urandom_range(cfg_stop, cfg_start - 1));
        return 17'($urandom_range(0, 65536));
    endfunction

    // mostly speech bursts followed by silence, some end-of-stream words and noise
    task automatic run_random(input int n_words);
        int sent, r, len, len_max, k;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(99);
            if (r < 72) begin
                len_max = (cfg_min_sp > 9) ? 12 : cfg_min_sp + 3;
                len = $urandom_range(1, len_max);
                for (k = 0; k < len; k++)
                    send_chunk(ACT_CHUNK, speech_p());
                sent += len;
                if ($urandom_range(3) == 0) begin
                    send_chunk(ACT_CHUNK, between_p());
                    sent++;
                end
                len_max = (cfg_min_sil > 9) ? 12 : cfg_min_sil + 3;
                len = $urandom_range(1, len_max);
                for (k = 0; k < len; k++)
                    send_chunk(ACT_CHUNK, quiet_p());
                sent += len;
            end else if (r < 84) begin
                send_chunk(ACT_END, 17'($urandom_range(0, 131071)));
                sent++;
            end else begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_chunk(ACT_CHUNK, 17'($urandom_range(0, 131071)));
                sent += len;
            end
        end
    endtask

    function automatic void plan_word(input logic act, input logic [16:0] p);
        plan_row_t row;
        row = '{ROW_WORD, act, p, ssd_pkg::REG_START_TH, 32'd0, 1'b0, 0, '0};
        plan.push_back(row);
    endfunction

    function automatic void plan_typed(input logic act, input logic [16:0] p,
                                       input int n, input seg_word_t res);
        plan_row_t row;
        row = '{ROW_WORD, act, p, ssd_pkg::REG_START_TH, 32'd0, 1'b1, n, res};
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input ssd_pkg::reg_idx_t ri, input logic [31:0] val);
        plan_row_t row;
        row = '{ROW_CFG, ACT_CHUNK, 17'd0, ri, val, 1'b0, 0, '0};
        plan.push_back(row);
    endfunction

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        seg_word_t want;
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall) begin
                segs_seen++;
                if (seg_expect.size() == 0) begin
                    $error("unexpected segment: start_chunk %0d end_chunk %0d",
                           start_chunk, end_chunk);
                    fails++;
                end else begin
                    want = seg_expect.pop_front();
                    if (start_chunk !== want.start_chunk) begin
                        $error("start_chunk: expected %0d, actual %0d",
                               want.start_chunk, start_chunk);
                        fails++;
                    end
                    if (end_chunk !== want.end_chunk) begin
                        $error("end_chunk: expected %0d, actual %0d", want.end_chunk, end_chunk);
                        fails++;
                    end
                    if (start_padded !== want.start_padded) begin
                        $error("start_padded: expected %0d, actual %0d",
                               want.start_padded, start_padded);
                        fails++;
                    end
                    if (end_padded !== want.end_padded) begin
                        $error("end_padded: expected %0d, actual %0d",
                               want.end_padded, end_padded);
                        fails++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d segments still expected",
                 cycle_count, seg_expect.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int ph;
        fails = 0; words_sent = 0; ends_sent = 0; segs_seen = 0; cfg_writes = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        action      <= ACT_CHUNK;
        probability <= '0;
        cfg_start   = ssd_pkg::START_TH_RST;
        cfg_stop    = ssd_pkg::STOP_TH_RST;
        cfg_min_sil = ssd_pkg::MIN_SIL_RST;
        cfg_min_sp  = ssd_pkg::MIN_SEG_RST;
        cfg_pad     = ssd_pkg::PAD_RST;
        clear_segments();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: end with nothing open, then one kept and one dropped segment
        plan_typed(ACT_END, 17'd131071, 0, '0);
        plan_word(ACT_CHUNK, 17'd65536);
        plan_word(ACT_CHUNK, 17'd65536);
        plan_word(ACT_CHUNK, 17'd40000);
        plan_word(ACT_CHUNK, 17'd40000);
        plan_word(ACT_CHUNK, 17'd0);
        plan_word(ACT_CHUNK, 17'd0);
        plan_word(ACT_CHUNK, 17'd0);
        plan_word(ACT_CHUNK, 17'd32768);
        plan_word(ACT_CHUNK, 17'd32767);
        plan_word(ACT_CHUNK, 17'd22937);
        plan_word(ACT_CHUNK, 17'd22938);
        plan_word(ACT_CHUNK, 17'd0);
        plan_typed(ACT_END, 17'd0, 1, '{24'd0, 24'd4, 32'd0, 32'd1104, 1'b1});
        // speech still open at end of stream
        for (int k = 0; k < 5; k++)
            plan_word(ACT_CHUNK, 17'd65536);
        plan_word(ACT_END, 17'd0);
        // stop above start, so the words are both above start and below stop
        plan_cfg(ssd_pkg::REG_STOP_TH, 32'd40000);
        plan_cfg(ssd_pkg::REG_START_TH, 32'd30000);
        for (int k = 0; k < 3; k++)
            plan_word(ACT_CHUNK, 17'd35000);
        // zero minimum silence and speech
        plan_cfg(ssd_pkg::REG_MIN_SIL, 32'd0);
        plan_cfg(ssd_pkg::REG_MIN_SEG, 32'd0);
        plan_word(ACT_CHUNK, 17'd0);
        plan_word(ACT_CHUNK, 17'd131071);
        plan_word(ACT_CHUNK, 17'd0);
        plan_word(ACT_END, 17'd65536);
        plan_cfg(ssd_pkg::REG_MIN_SEG, 32'd4095);
        plan_word(ACT_CHUNK, 17'd65536);
        plan_word(ACT_CHUNK, 17'd0);
        plan_typed(ACT_END, 17'd0, 0, '0);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_drain();
                cfg_write(plan[i].ri, plan[i].val);
            end else begin
                send_word(plan[i].act, plan[i].prob, plan[i].typed, plan[i].n_typed,
                          plan[i].res);
            end
        end

        for (ph = 0; ph < 4; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    cfg_random();
                end
                1: begin
                    send_idle_pct = 63; recv_stall_pct = 0;
                    cfg_all(65536, 65536, 1, 1, 0);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 63;
                    cfg_all(0, 0, 4095, 1, 65535);
                end
                default: begin
                    send_idle_pct = 16; recv_stall_pct = 16;
                    cfg_random();
                end
            endcase
            run_random(150);
        end

        // long receiver hold while words keep coming, then a full drain
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_all(32768, 20000, 1, 1, 100);
        hold_left = 300;
        run_random(80);
        wait_drain();
        send_idle_pct = 16;
        recv_stall_pct = 16;
        run_random(40);

        wait_drain();
        repeat (20) @(posedge clk);
        $display("run: %0d words in (%0d end-of-stream), %0d segments out, %0d register writes",
                 words_sent, ends_sent, segs_seen, cfg_writes);
        $display("idle mixes none/sender/receiver/both plus a long output hold");
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
